@@ design/vsrp_pkg.sv @@
// Package for the video scroll register port.
// Item, result and sprite-store write types, operation and register codes.
// No dependencies.
package vsrp_pkg;

    // Operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LINE  = 2'd2;

    // Register offsets from the port base
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // Scanline events
    localparam logic [8:0] LINE_VBLANK = 9'd241;
    localparam logic [8:0] LINE_PRE    = 9'd261;

    // Vertical scroll bits copied from t to v on the pre-render line
    localparam logic [15:0] VERT_MASK = 16'h7BE0;
    // Upper address bits of the palette page (0x3F00..0x3FFF)
    localparam logic [5:0]  PAL_PAGE  = 6'h3F;

    localparam int unsigned OAM_DEPTH = 256;
    localparam int unsigned PAL_DEPTH = 32;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [8:0] scanline;
        logic [7:0] external_data;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        nmi_pending;
        logic        frame_done;
        logic [13:0] vram_address;
        logic        ext_write_enable;
        logic [13:0] ext_write_address;
        logic [7:0]  ext_write_data;
    } result_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } oam_wr_t;

endpackage

@@ design/vsrp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module vsrp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/vsrp_oam.sv @@
// Sprite attribute store: 256-byte RAM plus per-entry valid bits so that
// entries not yet written read as zero. Depends on vsrp_pkg and vsrp_ram.
module vsrp_oam
    import vsrp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  oam_wr_t    wr,
    input  logic [7:0] raddr,
    output logic [7:0] rdata
);

    logic [OAM_DEPTH-1:0] valid_reg;
    logic                 rd_valid_reg;
    logic [7:0]           ram_q;

    vsrp_ram #(
        .WIDTH(8),
        .DEPTH(OAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // Valid bits; the read side samples the bit alongside the RAM data.
    // A write and a read never hit the same entry at the same edge: a data write
    // always moves the sprite address on by one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rd_valid_reg ? ram_q : 8'd0;

endmodule

@@ design/vsrp_regs.sv @@
// Register state and per-item update logic of the port: control, status,
// scroll/address registers, read buffer and palette. Depends on vsrp_pkg.
module vsrp_regs
    import vsrp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,          // item in the input register is processed
    input  item_t      item,
    input  logic [7:0] oam_rdata,     // sprite store at the current sprite address
    output result_t    res,
    output oam_wr_t    oam_wr,
    output logic [7:0] oam_raddr      // sprite address the next item will see
);

    logic [7:0]  ctrl_reg,      ctrl_next;
    logic        vblank_reg,    vblank_next;
    logic        nmi_reg,       nmi_next;
    logic        frame_reg,     frame_next;
    logic [7:0]  spr_addr_reg,  spr_addr_next;
    logic [14:0] t_reg,         t_next;
    logic [15:0] v_reg,         v_next;
    logic        toggle_reg,    toggle_next;
    logic [7:0]  rbuf_reg,      rbuf_next;
    logic [7:0]  pal_reg [PAL_DEPTH];

    logic [13:0] v14;
    logic        is_pal;
    logic [4:0]  pal_idx;
    logic [7:0]  pal_rd;
    logic [15:0] v_step;
    logic        pal_we;
    logic [7:0]  d;

    // Address decode for the data port
    always_comb begin
        v14     = v_reg[13:0];
        is_pal  = (v14[13:8] == PAL_PAGE);
        pal_idx = v14[4:0];
        // Sprite backdrop entries mirror the background ones
        if (pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
            pal_idx[4] = 1'b0;
        end
        pal_rd  = pal_reg[pal_idx];
        v_step  = v_reg + (ctrl_reg[2] ? 16'd32 : 16'd1);
        d       = item.write_data;
    end

    // Next state and result for the item in the input register
    always_comb begin
        ctrl_next     = ctrl_reg;
        vblank_next   = vblank_reg;
        nmi_next      = nmi_reg;
        frame_next    = frame_reg;
        spr_addr_next = spr_addr_reg;
        t_next        = t_reg;
        v_next        = v_reg;
        toggle_next   = toggle_reg;
        rbuf_next     = rbuf_reg;
        pal_we        = 1'b0;
        oam_wr        = '0;
        res           = '0;

        case (item.operation)
            OP_READ: begin
                case (item.reg_index)
                    REG_STATUS: begin
                        res.read_data = {vblank_reg, 7'd0};
                        vblank_next   = 1'b0;
                        toggle_next   = 1'b0;
                    end
                    REG_OAM_DATA: begin
                        res.read_data = oam_rdata;
                    end
                    REG_DATA: begin
                        // Palette reads bypass the buffer
                        if (is_pal) begin
                            rbuf_next     = pal_rd;
                            res.read_data = pal_rd;
                        end else begin
                            rbuf_next     = item.external_data;
                            res.read_data = rbuf_reg;
                        end
                        v_next = v_step;
                    end
                    default: begin
                    end
                endcase
            end
            OP_WRITE: begin
                case (item.reg_index)
                    REG_CTRL: begin
                        ctrl_next = d;
                        // NMI enable rising while in vblank raises the request
                        if (!ctrl_reg[7] && d[7] && vblank_reg) begin
                            nmi_next = 1'b1;
                        end
                        t_next[11:10] = d[1:0];
                    end
                    REG_OAM_ADDR: begin
                        spr_addr_next = d;
                    end
                    REG_OAM_DATA: begin
                        oam_wr.en     = 1'b1;
                        oam_wr.addr   = spr_addr_reg;
                        oam_wr.data   = d;
                        spr_addr_next = spr_addr_reg + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (!toggle_reg) begin
                            t_next[4:0] = d[7:3];
                            toggle_next = 1'b1;
                        end else begin
                            t_next[14:12] = d[2:0];
                            t_next[9:5]   = d[7:3];
                            toggle_next   = 1'b0;
                        end
                    end
                    REG_ADDR: begin
                        if (!toggle_reg) begin
                            t_next[14]   = 1'b0;
                            t_next[13:8] = d[5:0];
                            toggle_next  = 1'b1;
                        end else begin
                            t_next[7:0] = d;
                            v_next      = {1'b0, t_reg[14:8], d};
                            toggle_next = 1'b0;
                        end
                    end
                    REG_DATA: begin
                        if (is_pal) begin
                            pal_we = 1'b1;
                        end else begin
                            res.ext_write_enable  = 1'b1;
                            res.ext_write_address = v14;
                            res.ext_write_data    = d;
                        end
                        v_next = v_step;
                    end
                    default: begin
                        // Mask writes are ignored; status is read-only
                    end
                endcase
            end
            OP_LINE: begin
                if (item.scanline == LINE_VBLANK) begin
                    vblank_next = 1'b1;
                    nmi_next    = 1'b1;
                    frame_next  = 1'b1;
                end else if (item.scanline == LINE_PRE) begin
                    v_next      = (v_reg & ~VERT_MASK) | ({1'b0, t_reg} & VERT_MASK);
                    vblank_next = 1'b0;
                    nmi_next    = 1'b0;
                    frame_next  = 1'b0;
                end
            end
            default: begin
            end
        endcase

        res.nmi_pending    = nmi_next;
        res.frame_done     = frame_next;
        res.vram_address   = v_next[13:0];

        if (!fire) begin
            oam_wr.en = 1'b0;
        end
    end

    assign oam_raddr = fire ? spr_addr_next : spr_addr_reg;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg     <= '0;
            vblank_reg   <= 1'b0;
            nmi_reg      <= 1'b0;
            frame_reg    <= 1'b0;
            spr_addr_reg <= '0;
            t_reg        <= '0;
            v_reg        <= '0;
            toggle_reg   <= 1'b0;
            rbuf_reg     <= '0;
            for (int i = 0; i < PAL_DEPTH; i++) begin
                pal_reg[i] <= '0;
            end
        end else if (fire) begin
            ctrl_reg     <= ctrl_next;
            vblank_reg   <= vblank_next;
            nmi_reg      <= nmi_next;
            frame_reg    <= frame_next;
            spr_addr_reg <= spr_addr_next;
            t_reg        <= t_next;
            v_reg        <= v_next;
            toggle_reg   <= toggle_next;
            rbuf_reg     <= rbuf_next;
            if (pal_we) begin
                pal_reg[pal_idx] <= d;
            end
        end
    end

endmodule

@@ design/video_scroll_register_port_core.sv @@
// Top level of the video scroll register port.
// Depends on vsrp_pkg, vsrp_regs and vsrp_oam (which uses vsrp_ram).

// Each item (register read, register write or scanline event) is captured in
// an input register, processed by the register logic and placed in a result
// register: one result per item, at one item per clock while m_ready is high.
// m_valid rises once the item moves from the input to the result register.
// An empty input register takes a new item while a result waits on m_ready.
// Sprite store reads come from a 256-entry RAM with registered read data at
// the address the next item will see; entries never written read as zero.
// Data-port writes outside the palette page appear on the ext_write outputs;
// data-port reads expect s_external_data to hold the byte at the
// m_vram_address reported by the previous item. No clearing pass after reset.
module video_scroll_register_port_core
    import vsrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [2:0]  s_reg_index,
    input  logic [7:0]  s_write_data,
    input  logic [8:0]  s_scanline,
    input  logic [7:0]  s_external_data,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_nmi_pending,
    output logic        m_frame_done,
    output logic [13:0] m_vram_address,
    output logic        m_ext_write_enable,
    output logic [13:0] m_ext_write_address,
    output logic [7:0]  m_ext_write_data
);

    item_t   item_reg;
    logic    in_vld_reg;
    result_t res_reg;
    logic    out_vld_reg;

    logic    fire;
    result_t res;
    oam_wr_t oam_wr;
    logic [7:0] oam_raddr;
    logic [7:0] oam_rdata;

    // Pipeline control
    assign fire    = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || fire;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.operation     <= s_operation;
            item_reg.reg_index     <= s_reg_index;
            item_reg.write_data    <= s_write_data;
            item_reg.scanline      <= s_scanline;
            item_reg.external_data <= s_external_data;
        end
    end

    vsrp_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (item_reg),
        .oam_rdata (oam_rdata),
        .res       (res),
        .oam_wr    (oam_wr),
        .oam_raddr (oam_raddr)
    );

    vsrp_oam u_oam (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (oam_wr),
        .raddr   (oam_raddr),
        .rdata   (oam_rdata)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (fire) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res;
        end
    end

    assign m_valid             = out_vld_reg;
    assign m_read_data         = res_reg.read_data;
    assign m_nmi_pending       = res_reg.nmi_pending;
    assign m_frame_done        = res_reg.frame_done;
    assign m_vram_address      = res_reg.vram_address;
    assign m_ext_write_enable  = res_reg.ext_write_enable;
    assign m_ext_write_address = res_reg.ext_write_address;
    assign m_ext_write_data    = res_reg.ext_write_data;

    // External write fields are zero unless a write is flagged
    a_ext_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ext_write_enable) |->
            (m_ext_write_address == 14'd0) && (m_ext_write_data == 8'd0))
        else $error("ext write fields nonzero without enable");

    // External writes never land in the palette page
    a_ext_not_pal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ext_write_enable) |-> (m_ext_write_address[13:8] != PAL_PAGE))
        else $error("external write inside palette page");

    // Frame flag set only together with NMI and cleared together with it
    a_frame_nmi: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_done) |-> m_nmi_pending)
        else $error("frame done without pending NMI");

    // A stalled item stays in the input register
    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !fire) |=> in_vld_reg)
        else $error("input item dropped while stalled");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for video_scroll_register_port_core: a directed table, a sweep
// of the video address through its 16-bit wrap and random register traffic.
// Depends on vsrp_pkg and the design sources; results are checked by an in-bench predictor.
module tb_top;
    import vsrp_pkg::*;

    localparam logic [1:0] OP_NONE      = 2'd3;     // unused operation code
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         SWEEP_ITEMS  = 1100;     // enough +32 steps to pass 0xFFFF
    localparam int         RANDOM_ITEMS = 270;

    typedef struct {
        item_t   it;
        bit      known;
        result_t want;
    } directed_row_t;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation     = '0;
    logic [2:0]  s_reg_index     = '0;
    logic [7:0]  s_write_data    = '0;
    logic [8:0]  s_scanline      = '0;
    logic [7:0]  s_external_data = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [7:0]  m_read_data;
    logic        m_nmi_pending;
    logic        m_frame_done;
    logic [13:0] m_vram_address;
    logic        m_ext_write_enable;
    logic [13:0] m_ext_write_address;
    logic [7:0]  m_ext_write_data;

    // Predictor copy of the register port state
    logic [7:0]  ctrl_q;
    logic [7:0]  oam_ptr;
    logic [7:0]  data_buffer;
    logic        vblank_q, nmi_en_q, nmi_q, frame_q, latch_q;
    logic [14:0] t_addr;
    logic [15:0] v_addr;
    logic [7:0]  oam_mem [OAM_DEPTH];
    logic [7:0]  pal_mem [PAL_DEPTH];

    result_t       pending_port_results[$];
    directed_row_t directed_rows[$];
    int            mismatches      = 0;
    int            items_sent      = 0;
    int            results_checked = 0;
    int            cycle_count     = 0;
    int            tx_gap_max      = 3;
    int            rx_stall_max    = 3;
    bit            row_known       = 1'b0;
    result_t       row_want;

    always #10 aclk = ~aclk;

    video_scroll_register_port_core i_dut (.*);

    // Palette slot with the background-color mirrors folded down
    function automatic logic [4:0] pal_slot(input logic [13:0] a);
        logic [4:0] slot;
        slot = a[4:0];
        if (slot[4] && slot[1:0] == 2'd0)
            slot[4] = 1'b0;
        return slot;
    endfunction

    // Applies one item to the predictor state and returns the result it produces
    function automatic result_t compute_port_result(input item_t it);
        result_t     r;
        logic [13:0] a;
        logic [7:0]  d;
        r = '0;
        a = v_addr[13:0];
        d = it.write_data;
        case (it.operation)
            OP_READ: begin
                case (it.reg_index)
                    REG_STATUS: begin
                        r.read_data = {vblank_q, 7'd0};
                        vblank_q    = 1'b0;
                        latch_q     = 1'b0;
                    end
                    REG_OAM_DATA: r.read_data = oam_mem[oam_ptr];
                    REG_DATA: begin
                        // palette reads bypass the buffer
                        if (a[13:8] == PAL_PAGE) begin
                            data_buffer = pal_mem[pal_slot(a)];
                            r.read_data = data_buffer;
                        end else begin
                            r.read_data = data_buffer;
                            data_buffer = it.external_data;
                        end
                        v_addr = v_addr + (ctrl_q[2] ? 16'd32 : 16'd1);
                    end
                    default: ;
                endcase
            end
            OP_WRITE: begin
                // mask and fine x are not visible at the outputs
                case (it.reg_index)
                    REG_CTRL: begin
                        if (!nmi_en_q && d[7] && vblank_q)
                            nmi_q = 1'b1;
                        nmi_en_q      = d[7];
                        ctrl_q        = d;
                        t_addr[11:10] = d[1:0];
                    end
                    REG_OAM_ADDR: oam_ptr = d;
                    REG_OAM_DATA: begin
                        oam_mem[oam_ptr] = d;
                        oam_ptr          = oam_ptr + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (!latch_q) begin
                            t_addr[4:0] = d[7:3];
                        end else begin
                            t_addr[14:12] = d[2:0];
                            t_addr[9:5]   = d[7:3];
                        end
                        latch_q = ~latch_q;
                    end
                    REG_ADDR: begin
                        if (!latch_q) begin
                            t_addr[14:8] = {1'b0, d[5:0]};
                        end else begin
                            t_addr[7:0] = d;
                            v_addr      = {1'b0, t_addr};
                        end
                        latch_q = ~latch_q;
                    end
                    REG_DATA: begin
                        if (a[13:8] == PAL_PAGE) begin
                            pal_mem[pal_slot(a)] = d;
                        end else begin
                            r.ext_write_enable  = 1'b1;
                            r.ext_write_address = a;
                            r.ext_write_data    = d;
                        end
                        v_addr = v_addr + (ctrl_q[2] ? 16'd32 : 16'd1);
                    end
                    default: ;
                endcase
            end
            OP_LINE: begin
                if (it.scanline == LINE_VBLANK) begin
                    vblank_q = 1'b1;
                    nmi_q    = 1'b1;
                    frame_q  = 1'b1;
                end else if (it.scanline == LINE_PRE) begin
                    v_addr   = (v_addr & ~VERT_MASK) | ({1'b0, t_addr} & VERT_MASK);
                    vblank_q = 1'b0;
                    nmi_q    = 1'b0;
                    frame_q  = 1'b0;
                end
            end
            default: ;
        endcase
        r.nmi_pending    = nmi_q;
        r.frame_done     = frame_q;
        r.vram_address   = v_addr[13:0];
        return r;
    endfunction

    function automatic item_t rand_item(input logic [1:0] op, input logic [2:0] idx,
                                        input logic [7:0] wd);
        item_t it;
        it.operation     = op;
        it.reg_index     = idx;
        it.write_data    = wd;
        it.scanline      = 9'($urandom);
        it.external_data = 8'($urandom);
        return it;
    endfunction

    function automatic item_t line_item(input logic [8:0] sl);
        item_t it;
        it          = rand_item(OP_LINE, 3'($urandom), 8'($urandom));
        it.scanline = sl;
        return it;
    endfunction

    function automatic void add_row(input logic [1:0] op, input logic [2:0] idx,
                                    input logic [7:0] wd, input logic [8:0] sl,
                                    input logic [7:0] ext, input int known,
                                    input logic [7:0] rd, input int nmi,
                                    input int frame, input logic [13:0] va);
        directed_row_t row;
        row.it                  = '{op, idx, wd, sl, ext};
        row.known               = (known != 0);
        row.want                = '0;
        row.want.read_data      = rd;
        row.want.nmi_pending    = (nmi != 0);
        row.want.frame_done     = (frame != 0);
        row.want.vram_address   = va;
        directed_rows.push_back(row);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Presents one item after a random gap and records its expected result on acceptance
    task automatic send_item(input item_t it);
        int      gap;
        result_t predicted;
        gap = $urandom_range(tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= it.operation;
        s_reg_index     <= it.reg_index;
        s_write_data    <= it.write_data;
        s_scanline      <= it.scanline;
        s_external_data <= it.external_data;
        do @(posedge aclk); while (!s_ready);
        predicted = compute_port_result(it);
        pending_port_results.push_back(row_known ? row_want : predicted);
        items_sent++;
    endtask

    // Sender holds off until every outstanding result is back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_port_results.size() != 0);
    endtask

    // Stimulus
    initial begin
        int         kind;
        int         target;
        logic [7:0] oam_start;

        ctrl_q      = '0;
        oam_ptr     = '0;
        data_buffer = '0;
        vblank_q    = 1'b0;
        nmi_en_q    = 1'b0;
        nmi_q       = 1'b0;
        frame_q     = 1'b0;
        latch_q     = 1'b0;
        t_addr      = '0;
        v_addr      = '0;
        foreach (oam_mem[i]) oam_mem[i] = '0;
        foreach (pal_mem[i]) pal_mem[i] = '0;

        // op, reg, data, line, ext, known?, read, nmi, frame, vram
        add_row(OP_READ,  REG_STATUS,   8'hFF, 9'h1FF,      8'hFF, 1, 8'h00, 0, 0, 14'd0);
        add_row(OP_NONE,  REG_DATA,     8'hFF, 9'h1FF,      8'hFF, 1, 8'h00, 0, 0, 14'd0);
        add_row(OP_READ,  REG_OAM_DATA, 8'h00, 9'h000,      8'h00, 1, 8'h00, 0, 0, 14'd0);
        // buffered data-port reads outside the palette
        add_row(OP_READ,  REG_DATA,     8'h00, 9'h000,      8'h5A, 1, 8'h00, 0, 0, 14'd1);
        add_row(OP_READ,  REG_DATA,     8'h00, 9'h000,      8'h00, 1, 8'h5A, 0, 0, 14'd2);
        // vblank start, unrelated lines, status polls, pre-render line
        add_row(OP_LINE,  REG_CTRL,     8'h00, LINE_VBLANK, 8'h00, 1, 8'h00, 1, 1, 14'd2);
        add_row(OP_LINE,  REG_CTRL,     8'h00, 9'h000,      8'h00, 1, 8'h00, 1, 1, 14'd2);
        add_row(OP_LINE,  REG_DATA,     8'hFF, 9'h1FF,      8'hFF, 1, 8'h00, 1, 1, 14'd2);
        add_row(OP_READ,  REG_STATUS,   8'h00, 9'h000,      8'h00, 1, 8'h80, 1, 1, 14'd2);
        add_row(OP_READ,  REG_STATUS,   8'h00, 9'h000,      8'h00, 1, 8'h00, 1, 1, 14'd2);
        add_row(OP_LINE,  REG_CTRL,     8'h00, LINE_PRE,    8'h00, 1, 8'h00, 0, 0, 14'd2);
        // NMI enable during vblank, step of 32, scroll pair
        add_row(OP_LINE,  REG_CTRL,     8'h00, LINE_VBLANK, 8'h00, 0, 8'h00, 0, 0, 14'd0);
        add_row(OP_WRITE, REG_CTRL,     8'h87, 9'h000,      8'h00, 0, 8'h00, 0, 0, 14'd0);
        add_row(OP_WRITE, REG_SCROLL,   8'hFF, 9'h000,      8'h00, 0, 8'h00, 0, 0, 14'd0);
        add_row(OP_WRITE, REG_SCROLL,   8'hFF, 9'h000,      8'h00, 0, 8'h00, 0, 0, 14'd0);
        // palette write through a mirror, read back through the base entry
        add_row(OP_WRITE, REG_ADDR,     8'h3F, 9'h000,      8'h00, 0, 8'h00, 0, 0, 14'd0);
        add_row(OP_WRITE, REG_ADDR,     8'h10, 9'h000,      8'h00, 0, 8'h00, 0, 0, 14'd0);
        add_row(OP_WRITE, REG_DATA,     8'hC3, 9'h000,      8'h00, 0, 8'h00, 0, 0, 14'd0);
        add_row(OP_WRITE, REG_ADDR,     8'h3F, 9'h000,      8'h00, 0, 8'h00, 0, 0, 14'd0);
        add_row(OP_WRITE, REG_ADDR,     8'h00, 9'h000,      8'h00, 0, 8'h00, 0, 0, 14'd0);
        add_row(OP_READ,  REG_DATA,     8'h00, 9'h000,      8'hEE, 0, 8'h00, 0, 0, 14'd0);
        // external memory write
        add_row(OP_WRITE, REG_ADDR,     8'h20, 9'h000,      8'h00, 0, 8'h00, 0, 0, 14'd0);
        add_row(OP_WRITE, REG_ADDR,     8'h00, 9'h000,      8'h00, 0, 8'h00, 0, 0, 14'd0);
        add_row(OP_WRITE, REG_DATA,     8'h77, 9'h000,      8'h00, 0, 8'h00, 0, 0, 14'd0);
        // sprite address wraps after the last entry
        add_row(OP_WRITE, REG_OAM_ADDR, 8'hFF, 9'h000,      8'h00, 0, 8'h00, 0, 0, 14'd0);
        add_row(OP_WRITE, REG_OAM_DATA, 8'hA5, 9'h000,      8'h00, 0, 8'h00, 0, 0, 14'd0);
        add_row(OP_WRITE, REG_OAM_ADDR, 8'hFF, 9'h000,      8'h00, 0, 8'h00, 0, 0, 14'd0);
        add_row(OP_READ,  REG_OAM_DATA, 8'h00, 9'h000,      8'h00, 0, 8'h00, 0, 0, 14'd0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table
        foreach (directed_rows[i]) begin
            row_known = directed_rows[i].known;
            row_want  = directed_rows[i].want;
            send_item(directed_rows[i].it);
        end
        row_known = 1'b0;
        wait_for_results();

        // Load v = 0x7BE0 with a step of 32, then walk it past 0xFFFF
        send_item(rand_item(OP_READ,  REG_STATUS, 8'($urandom)));
        send_item(rand_item(OP_WRITE, REG_ADDR,   8'h00));
        send_item(rand_item(OP_WRITE, REG_ADDR,   8'h00));
        send_item(rand_item(OP_WRITE, REG_CTRL,   8'h07));
        send_item(rand_item(OP_WRITE, REG_SCROLL, 8'($urandom)));
        send_item(rand_item(OP_WRITE, REG_SCROLL, 8'hFF));
        send_item(line_item(LINE_PRE));
        for (int i = 0; i < SWEEP_ITEMS; i++) begin
            if (i % 100 == 0) begin
                tx_gap_max   = ($urandom_range(2) == 0) ? 0 : 3;
                rx_stall_max = ($urandom_range(2) == 0) ? 0 : 3;
            end
            send_item(rand_item($urandom_range(1) ? OP_WRITE : OP_READ, REG_DATA,
                                8'($urandom)));
        end
        wait_for_results();

        // Random register traffic, mostly well-formed access sequences
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            tx_gap_max   = ($urandom_range(5) == 0) ? 0 : 3;
            rx_stall_max = ($urandom_range(5) == 0) ? 0 : 3;
            kind         = $urandom_range(9);
            case (kind)
                0, 1: begin
                    send_item(rand_item(OP_READ,  REG_STATUS, 8'($urandom)));
                    send_item(rand_item(OP_WRITE, REG_SCROLL, 8'($urandom)));
                    send_item(rand_item(OP_WRITE, REG_SCROLL, 8'($urandom)));
                end
                2, 3: begin
                    // address pair, often into the palette page, then data accesses
                    send_item(rand_item(OP_READ,  REG_STATUS, 8'($urandom)));
                    send_item(rand_item(OP_WRITE, REG_ADDR,
                                        $urandom_range(1) ? 8'h3F : 8'($urandom)));
                    send_item(rand_item(OP_WRITE, REG_ADDR, 8'($urandom)));
                    repeat ($urandom_range(6, 1))
                        send_item(rand_item($urandom_range(1) ? OP_WRITE : OP_READ,
                                            REG_DATA, 8'($urandom)));
                end
                4: begin
                    // sprite store fill and read back
                    oam_start = 8'($urandom);
                    send_item(rand_item(OP_WRITE, REG_OAM_ADDR, oam_start));
                    repeat ($urandom_range(4, 1))
                        send_item(rand_item(OP_WRITE, REG_OAM_DATA, 8'($urandom)));
                    send_item(rand_item(OP_WRITE, REG_OAM_ADDR, oam_start));
                    repeat ($urandom_range(4, 1))
                        send_item(rand_item(OP_READ, REG_OAM_DATA, 8'($urandom)));
                end
                5: send_item(rand_item(OP_WRITE, REG_CTRL, 8'($urandom)));
                6: begin
                    // one frame: vblank, control write, status poll, pre-render
                    send_item(line_item(LINE_VBLANK));
                    send_item(rand_item(OP_WRITE, REG_CTRL, 8'($urandom)));
                    send_item(rand_item(OP_READ, REG_STATUS, 8'($urandom)));
                    send_item(line_item(LINE_PRE));
                end
                7: send_item(line_item(9'($urandom_range(LINE_PRE))));
                8: wait_for_results();
                default: send_item(rand_item(2'($urandom), 3'($urandom), 8'($urandom)));
            endcase
        end

        wait_for_results();
        repeat (10) @(posedge aclk);
        $display("Sent %0d items, checked %0d results: all registers read and written,",
                 items_sent, results_checked);
        $display("vblank and pre-render lines, palette mirrors, sprite wrap, full address wrap.");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side: random stalls, compare with the oldest expectation
    initial begin
        int      stall;
        result_t want;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = $urandom_range(rx_stall_max);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_checked++;
            if (pending_port_results.size() == 0) begin
                $error("result arrived with no item outstanding");
                mismatches++;
            end else begin
                want = pending_port_results.pop_front();
                check_field("read_data", 32'(want.read_data), 32'(m_read_data));
                check_field("nmi_pending", 32'(want.nmi_pending), 32'(m_nmi_pending));
                check_field("frame_done", 32'(want.frame_done), 32'(m_frame_done));
                check_field("vram_address", 32'(want.vram_address), 32'(m_vram_address));
                check_field("ext_write_enable", 32'(want.ext_write_enable),
                            32'(m_ext_write_enable));
                check_field("ext_write_address", 32'(want.ext_write_address),
                            32'(m_ext_write_address));
                check_field("ext_write_data", 32'(want.ext_write_data),
                            32'(m_ext_write_data));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_port_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

@@ video_scroll_register_port_core.f @@
design/vsrp_pkg.sv
design/vsrp_ram.sv
design/vsrp_oam.sv
design/vsrp_regs.sv
design/video_scroll_register_port_core.sv
sim/tb_top.sv
